/* sv/cfc_pkg.sv */
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, codes and lookup functions for the codepoint fold and
// classify pipeline.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int CP_W = 21;

    // Fold path chosen for an item
    typedef enum logic [2:0] {
        FK_CODE,
        FK_MARK,
        FK_LATIN1,
        FK_EXTA,
        FK_BYTES
    } fold_kind_t;

    // Case offset added ahead of re-encoding
    typedef enum logic [1:0] {
        ADD_NONE,
        ADD_20,
        ADD_50
    } case_add_t;

    typedef struct packed {
        logic is_token_char;
        logic is_digit;
        logic is_upper_ascii;
        logic is_lower_or_digit;
        logic is_underscore;
    } flags_t;

    // Decode stage result
    typedef struct packed {
        flags_t             flags;
        fold_kind_t         kind;
        case_add_t          add;
        logic [CP_W-1:0]    code;
    } dec_t;

    // Map stage result
    typedef struct packed {
        flags_t             flags;
        fold_kind_t         kind;
        logic [CP_W-1:0]    code;
        logic [1:0]         n;
        logic [7:0]         b0;
        logic [7:0]         b1;
    } map_t;

    // Final result item
    typedef struct packed {
        flags_t             flags;
        logic [2:0]         byte_count;
        logic [7:0]         byte_0;
        logic [7:0]         byte_1;
        logic [7:0]         byte_2;
        logic [7:0]         byte_3;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
    } letter_t;

    // Base letters for Latin Extended-A, first character for 0x100
    localparam logic [8*128-1:0] EXT_A_BASE =
        {"aaaaaaccccccccddddeeeeeeeeeegggggggghhhhiiiiiiiiiiiijjkkk",
         "llllllllllnnnnnnnnnoooooooorrrrrrssssssssttttttuuuuuuuuuuuu",
         "wwyyyzzzzzzs"};

    function automatic logic [7:0] ext_a_base(input logic [6:0] idx);
        logic [6:0] rev;
        begin
            rev = ~idx;
            return EXT_A_BASE[{rev, 3'b000} +: 8];
        end
    endfunction

    // Reduce a Latin-1 letter to its base letter or two-letter expansion
    function automatic letter_t latin1_fold(input logic [7:0] c);
        logic [7:0] u;
        letter_t    r;
        begin
            u = (c >= 8'hE0 && c != 8'hFF) ? c - 8'h20 : c;
            r.n  = 2'd1;
            r.b0 = "y";
            r.b1 = 8'h00;
            if (c != 8'hFF) begin
                case (u) inside
                    8'hDD:            r.b0 = "y";
                    [8'hC0:8'hC5]:    r.b0 = "a";
                    8'hC6:
                    begin
                        r.n  = 2'd2;
                        r.b0 = "a";
                        r.b1 = "e";
                    end
                    8'hC7:            r.b0 = "c";
                    [8'hC8:8'hCB]:    r.b0 = "e";
                    [8'hCC:8'hCF]:    r.b0 = "i";
                    8'hD0:            r.b0 = "d";
                    8'hD1:            r.b0 = "n";
                    [8'hD2:8'hD6],
                    8'hD8:            r.b0 = "o";
                    [8'hD9:8'hDC]:    r.b0 = "u";
                    8'hDE:
                    begin
                        r.n  = 2'd2;
                        r.b0 = "t";
                        r.b1 = "h";
                    end
                    8'hDF:
                    begin
                        r.n  = 2'd2;
                        r.b0 = "s";
                        r.b1 = "s";
                    end
                    default:
                    begin
                        r.n  = 2'd0;
                        r.b0 = 8'h00;
                    end
                endcase
            end
            return r;
        end
    endfunction

endpackage

/* sv/cfc_decode.sv */
// ----------------------------------------------------------------------------
// cfc_decode
// First stage: range tests on the codepoint, class flags and fold path.
// ----------------------------------------------------------------------------
module cfc_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    output logic                    stall_out,
    input  logic [cfc_pkg::CP_W-1:0] code_in,
    output logic                    valid_out,
    input  logic                    stall_in,
    output cfc_pkg::dec_t           data_out
);
    import cfc_pkg::*;

    logic            valid_reg;
    dec_t            data_reg;
    dec_t            data_next;
    logic            load;
    logic            digit;
    logic            upper;
    logic            lower;
    logic            under;
    logic            letter;
    logic            mark;
    logic            latin1;
    logic [CP_W-1:0] c;

    // Class flags and letter test
    always_comb
    begin
        c      = code_in;
        digit  = (c >= 21'h30) && (c <= 21'h39);
        upper  = (c >= 21'h41) && (c <= 21'h5A);
        lower  = (c >= 21'h61) && (c <= 21'h7A);
        under  = (c == 21'h5F);
        if (c < 21'h80) begin
            letter = upper || lower;
        end else begin
            letter = !((c <= 21'hBF) || (c == 21'hD7) || (c == 21'hF7)
                    || ((c >= 21'h2B0) && (c <= 21'h2FF))
                    || ((c >= 21'h2000) && (c <= 21'h2BFF))
                    || ((c >= 21'h2E00) && (c <= 21'h2E7F))
                    || ((c >= 21'h3000) && (c <= 21'h303F))
                    || ((c >= 21'hFE00) && (c <= 21'hFE0F))
                    || (c == 21'hFEFF)
                    || ((c >= 21'hFF01) && (c <= 21'hFF20)));
        end
        mark   = ((c >= 21'h300) && (c <= 21'h36F))
              || ((c >= 21'h1AB0) && (c <= 21'h1AFF))
              || ((c >= 21'h20D0) && (c <= 21'h20F0))
              || ((c >= 21'hFE20) && (c <= 21'hFE2F));
        latin1 = (c >= 21'hC0) && (c <= 21'hFF) && (c != 21'hD7) && (c != 21'hF7);
    end

    // Choose the fold path and case offset
    always_comb
    begin
        data_next.flags.is_token_char     = letter || digit || under;
        data_next.flags.is_digit          = digit;
        data_next.flags.is_upper_ascii    = upper;
        data_next.flags.is_lower_or_digit = lower || digit;
        data_next.flags.is_underscore     = under;
        data_next.code                    = c;
        data_next.kind                    = FK_CODE;
        data_next.add                     = ADD_NONE;
        if (c < 21'h80) begin
            data_next.add = upper ? ADD_20 : ADD_NONE;
        end else if (mark) begin
            data_next.kind = FK_MARK;
        end else if (latin1) begin
            data_next.kind = FK_LATIN1;
        end else if ((c >= 21'h100) && (c <= 21'h17F)) begin
            data_next.kind = FK_EXTA;
        end else if (((c >= 21'h391) && (c <= 21'h3A9))
                  || ((c >= 21'h410) && (c <= 21'h42F))) begin
            data_next.add = ADD_20;
        end else if ((c >= 21'h400) && (c <= 21'h40F)) begin
            data_next.add = ADD_50;
        end
    end

    // Stage register: advance unless the held item is stalled
    assign stall_out = valid_reg && stall_in;
    assign load      = !stall_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* sv/cfc_map.sv */
// ----------------------------------------------------------------------------
// cfc_map
// Second stage: base-letter lookup and case offset on the codepoint.
// ----------------------------------------------------------------------------
module cfc_map (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    output logic           stall_out,
    input  cfc_pkg::dec_t  data_in,
    output logic           valid_out,
    input  logic           stall_in,
    output cfc_pkg::map_t  data_out
);
    import cfc_pkg::*;

    logic    valid_reg;
    map_t    data_reg;
    map_t    data_next;
    logic    load;
    letter_t lat;

    // Fold letters to bytes, apply case offset to plain codepoints, pass marks on
    always_comb
    begin
        lat             = latin1_fold(data_in.code[7:0]);
        data_next.flags = data_in.flags;
        data_next.kind  = data_in.kind;
        data_next.code  = data_in.code;
        data_next.n     = 2'd0;
        data_next.b0    = 8'h00;
        data_next.b1    = 8'h00;
        case (data_in.kind)
            FK_LATIN1:
            begin
                data_next.kind = FK_BYTES;
                data_next.n    = lat.n;
                data_next.b0   = lat.b0;
                data_next.b1   = lat.b1;
            end
            FK_EXTA:
            begin
                data_next.kind = FK_BYTES;
                data_next.n    = 2'd1;
                data_next.b0   = ext_a_base(data_in.code[6:0]);
            end
            FK_CODE:
            begin
                case (data_in.add)
                    ADD_20:  data_next.code = data_in.code + 21'h20;
                    ADD_50:  data_next.code = data_in.code + 21'h50;
                    default: data_next.code = data_in.code;
                endcase
            end
            default:
            begin
                data_next.kind = data_in.kind;
            end
        endcase
    end

    // Stage register: advance unless the held item is stalled
    assign stall_out = valid_reg && stall_in;
    assign load      = !stall_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* sv/cfc_encode.sv */
// ----------------------------------------------------------------------------
// cfc_encode
// Third stage: UTF-8 encoding of the folded codepoint into the result item.
// ----------------------------------------------------------------------------
module cfc_encode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    output logic           stall_out,
    input  cfc_pkg::map_t  data_in,
    output logic           valid_out,
    input  logic           stall_in,
    output cfc_pkg::res_t  data_out
);
    import cfc_pkg::*;

    logic            valid_reg;
    res_t            data_reg;
    res_t            data_next;
    logic            load;
    logic [CP_W-1:0] c;

    // Build the output bytes
    always_comb
    begin
        c                    = data_in.code;
        data_next.flags      = data_in.flags;
        data_next.byte_count = 3'd0;
        data_next.byte_0     = 8'h00;
        data_next.byte_1     = 8'h00;
        data_next.byte_2     = 8'h00;
        data_next.byte_3     = 8'h00;
        case (data_in.kind)
            FK_BYTES:
            begin
                data_next.byte_count = {1'b0, data_in.n};
                data_next.byte_0     = data_in.b0;
                data_next.byte_1     = data_in.b1;
            end
            FK_CODE:
            begin
                if (c < 21'h80) begin
                    data_next.byte_count = 3'd1;
                    data_next.byte_0     = {1'b0, c[6:0]};
                end else if (c < 21'h800) begin
                    data_next.byte_count = 3'd2;
                    data_next.byte_0     = {3'b110, c[10:6]};
                    data_next.byte_1     = {2'b10, c[5:0]};
                end else if (c < 21'h10000) begin
                    data_next.byte_count = 3'd3;
                    data_next.byte_0     = {4'b1110, c[15:12]};
                    data_next.byte_1     = {2'b10, c[11:6]};
                    data_next.byte_2     = {2'b10, c[5:0]};
                end else begin
                    data_next.byte_count = 3'd4;
                    data_next.byte_0     = {5'b11110, c[20:18]};
                    data_next.byte_1     = {2'b10, c[17:12]};
                    data_next.byte_2     = {2'b10, c[11:6]};
                    data_next.byte_3     = {2'b10, c[5:0]};
                end
            end
            default:
            begin
                data_next.byte_count = 3'd0;
            end
        endcase
    end

    // Output register: advance unless the held item is stalled
    assign stall_out = valid_reg && stall_in;
    assign load      = !stall_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* sv/codepoint_fold_and_classify.sv */
// ----------------------------------------------------------------------------
// codepoint_fold_and_classify
// Tokenizer front end: classifies one codepoint and folds it to UTF-8 bytes.
// ----------------------------------------------------------------------------
// Path: input accept to result valid passes the decode, map and encode registers in order.
// Throughput: one item per cycle; each stage holds only while its item stalls.
// Reset: rst_n clears the stage valid bits at once; no memories, no warm-up.
// ----------------------------------------------------------------------------
module codepoint_fold_and_classify (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [20:0] code_point,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_token_char,
    output logic        is_digit,
    output logic        is_upper_ascii,
    output logic        is_lower_or_digit,
    output logic        is_underscore,
    output logic [2:0]  byte_count,
    output logic [7:0]  byte_0,
    output logic [7:0]  byte_1,
    output logic [7:0]  byte_2,
    output logic [7:0]  byte_3
);
    import cfc_pkg::*;

    logic dec_valid;
    logic dec_stall;
    dec_t dec_data;
    logic map_valid;
    logic map_stall;
    map_t map_data;
    res_t res;

    // Decode stage
    cfc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .stall_out (in_stall),
        .code_in   (code_point),
        .valid_out (dec_valid),
        .stall_in  (dec_stall),
        .data_out  (dec_data)
    );

    // Map stage
    cfc_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (dec_valid),
        .stall_out (dec_stall),
        .data_in   (dec_data),
        .valid_out (map_valid),
        .stall_in  (map_stall),
        .data_out  (map_data)
    );

    // Encode stage
    cfc_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (map_valid),
        .stall_out (map_stall),
        .data_in   (map_data),
        .valid_out (out_valid),
        .stall_in  (out_stall),
        .data_out  (res)
    );

    // Unpack the result item
    assign is_token_char     = res.flags.is_token_char;
    assign is_digit          = res.flags.is_digit;
    assign is_upper_ascii    = res.flags.is_upper_ascii;
    assign is_lower_or_digit = res.flags.is_lower_or_digit;
    assign is_underscore     = res.flags.is_underscore;
    assign byte_count        = res.byte_count;
    assign byte_0            = res.byte_0;
    assign byte_1            = res.byte_1;
    assign byte_2            = res.byte_2;
    assign byte_3            = res.byte_3;

endmodule

/* sv/cfc_checker.sv */
// ----------------------------------------------------------------------------
// cfc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cfc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        is_token_char,
    input  logic        is_digit,
    input  logic        is_upper_ascii,
    input  logic        is_lower_or_digit,
    input  logic        is_underscore,
    input  logic [2:0]  byte_count,
    input  logic [7:0]  byte_0,
    input  logic [7:0]  byte_1,
    input  logic [7:0]  byte_2,
    input  logic [7:0]  byte_3
);

    // Hold a stalled result item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_0) && $stable(byte_count)
            && $stable(is_token_char))
        else $error("stalled result item changed");

    // Unused bytes read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_count == 3'd0 || byte_count == 3'd1)
            |-> byte_1 == 8'h00 && byte_2 == 8'h00 && byte_3 == 8'h00)
        else $error("unused folded bytes not zero");

    // Capitals fold to one lower-case ASCII byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_upper_ascii |-> is_token_char && !is_lower_or_digit
            && byte_count == 3'd1 && byte_0 >= 8'h61 && byte_0 <= 8'h7A)
        else $error("upper-case ASCII not lowercased");

    // Digits and the underscore pass through as single bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (is_digit || is_underscore) |-> is_token_char && byte_count == 3'd1
            && !is_upper_ascii && (is_lower_or_digit == is_digit))
        else $error("digit or underscore misclassified");

endmodule

bind codepoint_fold_and_classify cfc_checker u_cfc_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the codepoint fold and classify pipeline. Each
// codepoint sent in is folded and classified by a behavioral predictor, and
// every result from the block is checked field by field against the oldest
// pending prediction. Directed tests hit the ASCII classes, Latin-1 and
// Latin Extended-A folds, combining marks, Greek and Cyrillic capitals and
// the wide encodings; a random test then covers the whole 21-bit space with
// bursty input and a receiver that stalls in several patterns.
// ----------------------------------------------------------------------------
module testbench;

    import cfc_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [20:0] code_point;
    logic        out_valid;
    logic        out_stall;
    logic        is_token_char;
    logic        is_digit;
    logic        is_upper_ascii;
    logic        is_lower_or_digit;
    logic        is_underscore;
    logic [2:0]  byte_count;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;

    res_t        fold_expect_q[$];
    int          err_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          idle_cycles = 0;
    bit          idle_en = 1'b1;
    int          burst_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_phase_left = 0;
    int          stall_hold = 0;

    codepoint_fold_and_classify dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .code_point        (code_point),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .is_token_char     (is_token_char),
        .is_digit          (is_digit),
        .is_upper_ascii    (is_upper_ascii),
        .is_lower_or_digit (is_lower_or_digit),
        .is_underscore     (is_underscore),
        .byte_count        (byte_count),
        .byte_0            (byte_0),
        .byte_1            (byte_1),
        .byte_2            (byte_2),
        .byte_3            (byte_3)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic within_span(input logic [20:0] c, input int lo, input int hi);
        begin
            return (c >= lo) && (c <= hi);
        end
    endfunction

    // Letter classification: ASCII letters, and everything above ASCII
    // except the punctuation, symbol and format blocks
    function automatic logic letter_class(input logic [20:0] c);
        begin
            if (c < 21'h80)
                return within_span(c, 'h41, 'h5A) || within_span(c, 'h61, 'h7A);
            if (within_span(c, 'h80, 'hBF) || c == 21'hD7 || c == 21'hF7)
                return 1'b0;
            if (within_span(c, 'h2B0, 'h2FF) || within_span(c, 'h2000, 'h2BFF))
                return 1'b0;
            if (within_span(c, 'h2E00, 'h2E7F) || within_span(c, 'h3000, 'h303F))
                return 1'b0;
            if (within_span(c, 'hFE00, 'hFE0F) || c == 21'hFEFF)
                return 1'b0;
            if (within_span(c, 'hFF01, 'hFF20))
                return 1'b0;
            return 1'b1;
        end
    endfunction

    // Base letter of a Latin Extended-A codepoint
    function automatic logic [7:0] ext_a_letter(input logic [20:0] c);
        begin
            if (c <= 21'h105) return "a";
            if (c <= 21'h10D) return "c";
            if (c <= 21'h111) return "d";
            if (c <= 21'h11B) return "e";
            if (c <= 21'h123) return "g";
            if (c <= 21'h127) return "h";
            if (c <= 21'h133) return "i";
            if (c <= 21'h135) return "j";
            if (c <= 21'h138) return "k";
            if (c <= 21'h142) return "l";
            if (c <= 21'h14B) return "n";
            if (c <= 21'h153) return "o";
            if (c <= 21'h159) return "r";
            if (c <= 21'h161) return "s";
            if (c <= 21'h167) return "t";
            if (c <= 21'h173) return "u";
            if (c <= 21'h175) return "w";
            if (c <= 21'h178) return "y";
            if (c <= 21'h17E) return "z";
            return "s";
        end
    endfunction

    // Expected flags and folded bytes for one codepoint
    function automatic res_t predict_fold(input logic [20:0] cp);
        res_t        r;
        logic [20:0] c;
        logic [7:0]  u;
        logic        folded;
        begin
            r = '0;
            c = cp;
            folded = 1'b0;
            r.flags.is_digit          = within_span(cp, 'h30, 'h39);
            r.flags.is_upper_ascii    = within_span(cp, 'h41, 'h5A);
            r.flags.is_underscore     = (cp == 21'h5F);
            r.flags.is_lower_or_digit = within_span(cp, 'h61, 'h7A) || r.flags.is_digit;
            r.flags.is_token_char     = letter_class(cp) || r.flags.is_digit
                                        || r.flags.is_underscore;

            if (c < 21'h80)
            begin
                // lowercase ASCII capitals
                r.byte_count = 3'd1;
                r.byte_0 = r.flags.is_upper_ascii ? c[7:0] + 8'h20 : c[7:0];
                folded = 1'b1;
            end
            else if (within_span(c, 'h300, 'h36F) || within_span(c, 'h1AB0, 'h1AFF)
                     || within_span(c, 'h20D0, 'h20F0) || within_span(c, 'hFE20, 'hFE2F))
            begin
                // drop combining marks
                folded = 1'b1;
            end
            else if (within_span(c, 'hC0, 'hFF) && c != 21'hD7 && c != 21'hF7)
            begin
                // reduce Latin-1 letters, small ones share the capital's row
                u = (c >= 21'hE0 && c != 21'hFF) ? c[7:0] - 8'h20 : c[7:0];
                r.byte_count = 3'd1;
                if (c == 21'hFF || u == 8'hDD) r.byte_0 = "y";
                else if (u <= 8'hC5) r.byte_0 = "a";
                else if (u == 8'hC6) begin r.byte_0 = "a"; r.byte_1 = "e"; end
                else if (u == 8'hC7) r.byte_0 = "c";
                else if (u <= 8'hCB) r.byte_0 = "e";
                else if (u <= 8'hCF) r.byte_0 = "i";
                else if (u == 8'hD0) r.byte_0 = "d";
                else if (u == 8'hD1) r.byte_0 = "n";
                else if (u <= 8'hD8) r.byte_0 = "o";
                else if (u <= 8'hDC) r.byte_0 = "u";
                else if (u == 8'hDE) begin r.byte_0 = "t"; r.byte_1 = "h"; end
                else begin r.byte_0 = "s"; r.byte_1 = "s"; end
                if (r.byte_1 != 8'h00)
                    r.byte_count = 3'd2;
                folded = 1'b1;
            end
            else if (within_span(c, 'h100, 'h17F))
            begin
                r.byte_count = 3'd1;
                r.byte_0 = ext_a_letter(c);
                folded = 1'b1;
            end

            if (!folded)
            begin
                // lowercase Greek and Cyrillic capitals, then re-encode
                if (within_span(c, 'h391, 'h3A9) || within_span(c, 'h410, 'h42F))
                    c = c + 21'h20;
                else if (within_span(c, 'h400, 'h40F))
                    c = c + 21'h50;

                if (c < 21'h800)
                begin
                    r.byte_count = 3'd2;
                    r.byte_0 = {3'b110, c[10:6]};
                    r.byte_1 = {2'b10, c[5:0]};
                end
                else if (c < 21'h10000)
                begin
                    r.byte_count = 3'd3;
                    r.byte_0 = {4'b1110, c[15:12]};
                    r.byte_1 = {2'b10, c[11:6]};
                    r.byte_2 = {2'b10, c[5:0]};
                end
                else
                begin
                    r.byte_count = 3'd4;
                    r.byte_0 = {5'b11110, c[20:18]};
                    r.byte_1 = {2'b10, c[17:12]};
                    r.byte_2 = {2'b10, c[11:6]};
                    r.byte_3 = {2'b10, c[5:0]};
                end
            end
            return r;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of items with random gaps, payload held while stalled
    // ------------------------------------------------------------------------

    task automatic send_code(input logic [20:0] cp);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = idle_en ? $urandom_range(1, 16) : 1000000;
                gap = idle_en ? $urandom_range(1, 6) : 0;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid   <= 1'b1;
            code_point <= cp;
            // accepted at the edge after a negedge that sees no stall
            do
                @(negedge clk);
            while (in_stall);
            fold_expect_q = {fold_expect_q, predict_fold(cp)};
            sent_count++;
            @(posedge clk);
        end
    endtask

    task automatic set_idling(input bit on);
        begin
            idle_en = on;
            burst_left = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern; each phase draws a new mode and its length in cycles
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_phase_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_phase_left = $urandom_range(20, 80);
            end
            stall_phase_left--;
            if (stall_hold > 0)
                stall_hold--;
            else if (stall_mode == STALL_LONG && $urandom_range(0, 7) == 0)
                stall_hold = $urandom_range(1, 12);

            if (!idle_en)
                out_stall <= 1'b0;
            else
            begin
                case (stall_mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PERIODIC: out_stall <= (stall_phase_left % 3 != 0);
                    default:        out_stall <= (stall_hold != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker and watchdog, sampled at negedge where signals are stable
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        begin
            if (exp_v !== act_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                err_count++;
            end
        end
    endtask

    always @(negedge clk)
    begin
        res_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (fold_expect_q.size() == 0)
            begin
                $error("result item with no pending prediction");
                err_count++;
            end
            else
            begin
                exp_r = fold_expect_q.pop_front();
                check_field("is_token_char", exp_r.flags.is_token_char, is_token_char);
                check_field("is_digit", exp_r.flags.is_digit, is_digit);
                check_field("is_upper_ascii", exp_r.flags.is_upper_ascii, is_upper_ascii);
                check_field("is_lower_or_digit", exp_r.flags.is_lower_or_digit,
                            is_lower_or_digit);
                check_field("is_underscore", exp_r.flags.is_underscore, is_underscore);
                check_field("byte_count", exp_r.byte_count, byte_count);
                check_field("byte_0", exp_r.byte_0, byte_0);
                check_field("byte_1", exp_r.byte_1, byte_1);
                check_field("byte_2", exp_r.byte_2, byte_2);
                check_field("byte_3", exp_r.byte_3, byte_3);
                checked_count++;
            end
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Digits, capitals, underscore and the ends of the ASCII range
    task automatic test_ascii_classes;
        begin
            send_code(21'h00);
            send_code(21'h30);
            send_code(21'h39);
            send_code(21'h41);
            send_code(21'h5A);
            send_code(21'h5F);
            send_code(21'h7A);
            send_code(21'h7F);
        end
    endtask

    // Two-letter expansions, y with diaeresis, multiplication and division signs
    task automatic test_latin1_folds;
        begin
            send_code(21'hC6);
            send_code(21'hD7);
            send_code(21'hDE);
            send_code(21'hDF);
            send_code(21'hF7);
            send_code(21'hFF);
        end
    endtask

    // IJ and OE ligatures reduce to one letter
    task automatic test_ligatures;
        begin
            send_code(21'h132);
            send_code(21'h152);
        end
    endtask

    // One mark from each combining block, including the top of the symbol block
    task automatic test_combining_marks;
        begin
            send_code(21'h300);
            send_code(21'h1AB0);
            send_code(21'h20F0);
            send_code(21'hFE20);
        end
    endtask

    // Unassigned Greek capital and both Cyrillic capital ranges
    task automatic test_greek_cyrillic;
        begin
            send_code(21'h3A2);
            send_code(21'h400);
            send_code(21'h42F);
        end
    endtask

    // Surrogate, last valid codepoint, and the top of the 21-bit space
    task automatic test_wide_encodings;
        begin
            send_code(21'hD800);
            send_code(21'h10FFFF);
            send_code(21'h1FFFFF);
        end
    endtask

    function automatic logic [20:0] pick_near(input int lo, input int hi);
        begin
            return 21'($urandom_range(lo - 3, hi + 3));
        end
    endfunction

    // Random codepoints weighted toward the blocks with special handling
    task automatic test_random_codepoints(input int count);
        logic [20:0] cp;
        begin
            set_idling(1'b0);
            for (int i = 0; i < count; i++)
            begin
                if (i == count / 6)
                    set_idling(1'b1);
                case ($urandom_range(0, 15))
                    0, 1, 2: cp = 21'($urandom_range(0, 'h7F));
                    3, 4:    cp = 21'($urandom_range('h80, 'hFF));
                    5:       cp = 21'($urandom_range('h100, 'h17F));
                    6:
                    begin
                        case ($urandom_range(0, 3))
                            0:       cp = pick_near('h300, 'h36F);
                            1:       cp = pick_near('h1AB0, 'h1AFF);
                            2:       cp = pick_near('h20D0, 'h20F0);
                            default: cp = pick_near('hFE20, 'hFE2F);
                        endcase
                    end
                    7:       cp = 21'($urandom_range('h380, 'h47F));
                    8:
                    begin
                        case ($urandom_range(0, 5))
                            0:       cp = pick_near('h2B0, 'h2FF);
                            1:       cp = pick_near('h2000, 'h2BFF);
                            2:       cp = pick_near('h2E00, 'h2E7F);
                            3:       cp = pick_near('h3000, 'h303F);
                            4:       cp = pick_near('hFE00, 'hFE0F);
                            default: cp = pick_near('hFEFF, 'hFF20);
                        endcase
                    end
                    9:       cp = 21'($urandom_range('h80, 'h7FF));
                    10:      cp = 21'($urandom_range('h800, 'hFFFF));
                    11:      cp = 21'($urandom_range('hD800, 'hDFFF));
                    12:      cp = 21'($urandom_range('h10000, 'h10FFFF));
                    13:      cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    default: cp = 21'($urandom_range(0, 'h1FFFFF));
                endcase
                send_code(cp);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        code_point <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_classes();
        test_latin1_folds();
        test_ligatures();
        test_combining_marks();
        test_greek_cyrillic();
        test_wide_encodings();
        test_random_codepoints(RANDOM_ITEMS);

        // drain the pipeline, then watch for stray results
        in_valid <= 1'b0;
        while (fold_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fold_expect_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", fold_expect_q.size());
            err_count++;
        end

        $display("Sent %0d codepoints (directed class, fold, mark and encoding cases,",
                 sent_count);
        $display("then weighted random over 21 bits); checked %0d results, %0d errors",
                 checked_count, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
